// ===== sv/v3a_pkg.sv =====
// Shared types and constants for the fixed-point 3D vector unit.
// No dependencies; used by vector3_arith_unit, v3a_isqrt and v3a_divider.
package v3a_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_W    = 2 * DATA_W + 2;        // exact sum of three products
  localparam int RAD_W     = 2 * DATA_W;            // sum of squares
  localparam int ROOT_W    = RAD_W / 2;
  localparam int NUM_W     = DATA_W + FRAC_BITS;    // normalize dividend
  localparam int SQ_STEPS  = 2;                     // root bits per stage
  localparam int DIV_STEPS = 2;                     // quotient bits per stage
  localparam int SQ_STAGES  = ROOT_W / SQ_STEPS;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] scale_factor;
  } v3a_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_z;
    logic signed [DATA_W-1:0] scalar_out;
    logic                     overflow;
    logic                     zero_length;
  } v3a_out_t;

  // Rides along with the root and divide pipelines.
  typedef struct packed {
    logic [2:0]              op;
    logic [2:0]              a_neg;
    logic [2:0][DATA_W-1:0]  a_mag;
    v3a_out_t                res;    // finished result for the short ops
  } v3a_side_t;

endpackage

// ===== sv/vector3_arith_unit.sv =====
// Top level of the Q16.16 3D vector unit: front stages, root, divide, output.
// Depends on v3a_pkg, v3a_isqrt and v3a_divider.
//
//   channel  ports                 handshake
//   input    start, busy, in_data  beat taken when start && !busy
//   result   out_strobe, out_data  one-cycle strobe, receiver cannot stall
//
// One beat per cycle, and every operation passes through the same stages:
// 5 front stages (register, multiply, sum, sign split, round/saturate),
// 16 square-root stages, 1 dividend stage, 24 divider stages, 1 output register.
// busy stays low; results leave in input order. Reset clears the valid bits only.
module vector3_arith_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  v3a_pkg::v3a_in_t    in_data,
  output logic                busy,
  output logic                out_strobe,
  output v3a_pkg::v3a_out_t   out_data
);

  localparam int DW = v3a_pkg::DATA_W;
  localparam int WW = v3a_pkg::WIDE_W;
  localparam int FB = v3a_pkg::FRAC_BITS;
  localparam int NW = v3a_pkg::NUM_W;
  localparam int RW = v3a_pkg::ROOT_W;
  localparam logic [WW-1:0] POS_LIM  = (WW'(1) << (DW - 1)) - WW'(1);
  localparam logic [WW-1:0] NEG_LIM  = WW'(1) << (DW - 1);
  localparam logic [WW-1:0] RND_HALF = WW'(1) << (FB - 1);

  // clamp a sign/magnitude value; returns {saturated, two's complement}
  function automatic logic [DW:0] sat_val(input logic neg, input logic [WW-1:0] mag);
    logic [WW-1:0] m;
    logic          o;
    m = mag;
    o = 1'b0;
    if (!neg && mag > POS_LIM) begin
      m = POS_LIM;
      o = 1'b1;
    end else if (neg && mag > NEG_LIM) begin
      m = NEG_LIM;
      o = 1'b1;
    end
    return {o, neg ? (~m[DW-1:0] + DW'(1)) : m[DW-1:0]};
  endfunction

  assign busy = 1'b0;

  // stage 1: input register
  logic              v1_r;
  v3a_pkg::v3a_in_t  it1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    it1_r <= in_data;
  end

  // stage 2: operand select and products
  logic signed [DW-1:0]   a1 [3];
  logic signed [DW-1:0]   b1 [3];
  logic signed [DW-1:0]   ma [6];
  logic signed [DW-1:0]   mb [6];
  logic signed [2*DW-1:0] p_nxt [6];
  logic signed [DW:0]     as_nxt [3];

  logic                   v2_r;
  logic [2:0]             op2_r;
  logic signed [DW-1:0]   a2_r  [3];
  logic signed [2*DW-1:0] p2_r  [6];
  logic signed [DW:0]     as2_r [3];

  assign a1[0] = it1_r.a_x;
  assign a1[1] = it1_r.a_y;
  assign a1[2] = it1_r.a_z;
  assign b1[0] = it1_r.b_x;
  assign b1[1] = it1_r.b_y;
  assign b1[2] = it1_r.b_z;

  always_comb begin
    // dot by default; the upper three feed the cross subtrahends
    for (int i = 0; i < 3; i++) begin
      ma[i] = a1[i];
      mb[i] = b1[i];
    end
    ma[3] = a1[2];  mb[3] = b1[1];
    ma[4] = a1[0];  mb[4] = b1[2];
    ma[5] = a1[1];  mb[5] = b1[0];
    unique case (it1_r.operation)
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = it1_r.scale_factor;
          mb[i] = a1[i];
        end
      end
      v3a_pkg::OP_CROSS: begin
        ma[0] = a1[1];  mb[0] = b1[2];
        ma[1] = a1[2];  mb[1] = b1[0];
        ma[2] = a1[0];  mb[2] = b1[1];
      end
      v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) mb[i] = a1[i];
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) p_nxt[i] = ma[i] * mb[i];
    for (int i = 0; i < 3; i++) begin
      if (it1_r.operation == v3a_pkg::OP_SUB) as_nxt[i] = (DW+1)'(a1[i]) - (DW+1)'(b1[i]);
      else                                    as_nxt[i] = (DW+1)'(a1[i]) + (DW+1)'(b1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    op2_r <= it1_r.operation;
    for (int i = 0; i < 3; i++) begin
      a2_r[i]  <= a1[i];
      as2_r[i] <= as_nxt[i];
    end
    for (int i = 0; i < 6; i++) p2_r[i] <= p_nxt[i];
  end

  // stage 3: exact sums
  logic signed [WW-1:0] lv_nxt [3];
  logic signed [WW-1:0] sv_nxt;
  logic                 rnd_nxt;

  logic                 v3_r;
  logic [2:0]           op3_r;
  logic signed [DW-1:0] a3_r  [3];
  logic signed [WW-1:0] lv3_r [3];
  logic signed [WW-1:0] sv3_r;
  logic                 rnd3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) lv_nxt[i] = WW'(as2_r[i]);
    sv_nxt  = '0;
    rnd_nxt = 1'b0;
    unique case (op2_r)
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) lv_nxt[i] = WW'(p2_r[i]);
        rnd_nxt = 1'b1;
      end
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) lv_nxt[i] = WW'(p2_r[i]) - WW'(p2_r[i+3]);
        rnd_nxt = 1'b1;
      end
      v3a_pkg::OP_DOT, v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: begin
        sv_nxt  = WW'(p2_r[0]) + WW'(p2_r[1]) + WW'(p2_r[2]);
        rnd_nxt = (op2_r == v3a_pkg::OP_DOT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    sv3_r  <= sv_nxt;
    rnd3_r <= rnd_nxt;
    for (int i = 0; i < 3; i++) begin
      a3_r[i]  <= a2_r[i];
      lv3_r[i] <= lv_nxt[i];
    end
  end

  // stage 4: sign/magnitude split; lane 3 is the scalar
  logic signed [WW-1:0] wv [4];
  logic                 v4_r;
  logic [2:0]           op4_r;
  logic signed [DW-1:0] a4_r   [3];
  logic                 neg4_r [4];
  logic [WW-1:0]        mag4_r [4];
  logic                 rnd4_r;
  logic [v3a_pkg::RAD_W-1:0] sq4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) wv[i] = lv3_r[i];
    wv[3] = sv3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    op4_r  <= op3_r;
    rnd4_r <= rnd3_r;
    sq4_r  <= sv3_r[v3a_pkg::RAD_W-1:0];
    for (int i = 0; i < 3; i++) a4_r[i] <= a3_r[i];
    for (int j = 0; j < 4; j++) begin
      neg4_r[j] <= wv[j][WW-1];
      mag4_r[j] <= wv[j][WW-1] ? WW'(-wv[j]) : WW'(wv[j]);
    end
  end

  // stage 5: round, saturate, finish the short ops
  logic [WW-1:0]       rm   [4];
  logic [DW:0]         sres [4];
  logic                is_vec;
  logic                is_scal;
  v3a_pkg::v3a_side_t  side_nxt;

  logic                      v5_r;
  v3a_pkg::v3a_side_t        side5_r;
  logic [v3a_pkg::RAD_W-1:0] sq5_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rm[j]   = rnd4_r ? ((mag4_r[j] + RND_HALF) >> FB) : mag4_r[j];
      sres[j] = sat_val(neg4_r[j], rm[j]);
    end
    is_vec  = 1'b0;
    is_scal = 1'b0;
    unique case (op4_r)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: is_vec = 1'b1;
      v3a_pkg::OP_DOT: is_scal = 1'b1;
      default: ;
    endcase
    side_nxt.op = op4_r;
    for (int i = 0; i < 3; i++) begin
      side_nxt.a_neg[i] = a4_r[i][DW-1];
      side_nxt.a_mag[i] = a4_r[i][DW-1] ? (~a4_r[i] + DW'(1)) : a4_r[i];
    end
    side_nxt.res.r_x         = is_vec  ? sres[0][DW-1:0] : '0;
    side_nxt.res.r_y         = is_vec  ? sres[1][DW-1:0] : '0;
    side_nxt.res.r_z         = is_vec  ? sres[2][DW-1:0] : '0;
    side_nxt.res.scalar_out  = is_scal ? sres[3][DW-1:0] : '0;
    side_nxt.res.overflow    = (is_vec & (sres[0][DW] | sres[1][DW] | sres[2][DW]))
                             | (is_scal & sres[3][DW]);
    side_nxt.res.zero_length = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    side5_r <= side_nxt;
    sq5_r   <= sq4_r;
  end

  // square root of the sum of squares
  logic                sq_valid;
  logic [RW-1:0]       sq_root;
  v3a_pkg::v3a_side_t  sq_side;

  v3a_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_rad    (sq5_r),
    .in_side   (side5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // dividend: |a| scaled up, plus half the divisor for round-to-nearest
  logic               vp_r;
  logic [RW-1:0]      pm_r;
  logic [2:0][NW-1:0] pnum_r;
  v3a_pkg::v3a_side_t pside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= sq_valid;
  end

  always_ff @(posedge clk) begin
    pm_r    <= sq_root;
    pside_r <= sq_side;
    for (int i = 0; i < 3; i++) begin
      pnum_r[i] <= {sq_side.a_mag[i], {FB{1'b0}}} + NW'(sq_root >> 1);
    end
  end

  logic               dv_valid;
  logic [RW-1:0]      dv_m;
  logic [2:0][NW-1:0] dv_quot;
  v3a_pkg::v3a_side_t dv_side;

  v3a_divider u_divider (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vp_r),
    .in_divisor  (pm_r),
    .in_num      (pnum_r),
    .in_side     (pside_r),
    .out_valid   (dv_valid),
    .out_divisor (dv_m),
    .out_quot    (dv_quot),
    .out_side    (dv_side)
  );

  // output stage
  logic [DW:0]        nres [3];
  logic [DW:0]        mres;
  v3a_pkg::v3a_out_t  out_nxt;
  logic               vout_r;
  v3a_pkg::v3a_out_t  out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) nres[i] = sat_val(dv_side.a_neg[i], WW'(dv_quot[i]));
    mres    = sat_val(1'b0, WW'(dv_m));
    out_nxt = dv_side.res;
    unique case (dv_side.op)
      v3a_pkg::OP_MAG: begin
        out_nxt            = '0;
        out_nxt.scalar_out = mres[DW-1:0];
        out_nxt.overflow   = mres[DW];
      end
      v3a_pkg::OP_NORM: begin
        out_nxt = '0;
        if (dv_m == '0) begin
          out_nxt.zero_length = 1'b1;
        end else begin
          out_nxt.r_x      = nres[0][DW-1:0];
          out_nxt.r_y      = nres[1][DW-1:0];
          out_nxt.r_z      = nres[2][DW-1:0];
          out_nxt.overflow = nres[0][DW] | nres[1][DW] | nres[2][DW];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vout_r <= 1'b0;
    else        vout_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = vout_r;
  assign out_data   = out_r;

endmodule

// ===== sv/v3a_isqrt.sv =====
// Pipelined integer square root, two root bits per stage, with sideband.
// Depends on v3a_pkg.
module v3a_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [v3a_pkg::RAD_W-1:0]    in_rad,
  input  v3a_pkg::v3a_side_t           in_side,
  output logic                         out_valid,
  output logic [v3a_pkg::ROOT_W-1:0]   out_root,
  output v3a_pkg::v3a_side_t           out_side
);

  localparam int NS    = v3a_pkg::SQ_STAGES;
  localparam int RW    = v3a_pkg::ROOT_W;
  localparam int RADW  = v3a_pkg::RAD_W;
  localparam int REM_W = RW + 2;

  logic                 vld_r  [NS];
  logic [REM_W-1:0]     rem_r  [NS];
  logic [RW-1:0]        root_r [NS];
  logic [RADW-1:0]      rad_r  [NS];
  v3a_pkg::v3a_side_t   side_r [NS];

  // one restoring step: bring down two radicand bits, try 4q+1
  function automatic void sq_step(input  logic [REM_W-1:0] ri,
                                  input  logic [RW-1:0]    qi,
                                  input  logic [RADW-1:0]  di,
                                  output logic [REM_W-1:0] ro,
                                  output logic [RW-1:0]    qo,
                                  output logic [RADW-1:0]  dout);
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] test;
    trial = {ri, di[RADW-1 -: 2]};
    test  = {2'b00, qi, 2'b01};
    if (trial >= test) begin
      ro = REM_W'(trial - test);
      qo = {qi[RW-2:0], 1'b1};
    end else begin
      ro = REM_W'(trial);
      qo = {qi[RW-2:0], 1'b0};
    end
    dout = {di[RADW-3:0], 2'b00};
  endfunction

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic               vin;
    logic [REM_W-1:0]   rem_in;
    logic [RW-1:0]      root_in;
    logic [RADW-1:0]    rad_in;
    v3a_pkg::v3a_side_t side_in;
    logic [REM_W-1:0]   rem_v;
    logic [RW-1:0]      root_v;
    logic [RADW-1:0]    rad_v;

    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vin     = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_v  = rem_in;
      root_v = root_in;
      rad_v  = rad_in;
      for (int s = 0; s < v3a_pkg::SQ_STEPS; s++) begin
        sq_step(rem_v, root_v, rad_v, rem_v, root_v, rad_v);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vin;
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_v;
      root_r[k] <= root_v;
      rad_r[k]  <= rad_v;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ===== sv/v3a_divider.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, with sideband.
// Depends on v3a_pkg.
module v3a_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [v3a_pkg::ROOT_W-1:0]          in_divisor,
  input  logic [2:0][v3a_pkg::NUM_W-1:0]      in_num,
  input  v3a_pkg::v3a_side_t                  in_side,
  output logic                                out_valid,
  output logic [v3a_pkg::ROOT_W-1:0]          out_divisor,
  output logic [2:0][v3a_pkg::NUM_W-1:0]      out_quot,
  output v3a_pkg::v3a_side_t                  out_side
);

  localparam int NS = v3a_pkg::DIV_STAGES;
  localparam int DW = v3a_pkg::ROOT_W;
  localparam int NW = v3a_pkg::NUM_W;

  logic                   vld_r  [NS];
  logic [DW-1:0]          dvs_r  [NS];
  logic [2:0][DW-1:0]     rem_r  [NS];
  logic [2:0][NW-1:0]     num_r  [NS];   // dividend shifts out, quotient shifts in
  v3a_pkg::v3a_side_t     side_r [NS];

  function automatic void dv_step(input  logic [DW-1:0] ri,
                                  input  logic [NW-1:0] ni,
                                  input  logic [DW-1:0] d,
                                  output logic [DW-1:0] ro,
                                  output logic [NW-1:0] no);
    logic [DW:0] t;
    t = {ri, ni[NW-1]};
    if (t >= {1'b0, d}) begin
      ro = DW'(t - {1'b0, d});
      no = {ni[NW-2:0], 1'b1};
    end else begin
      ro = DW'(t);
      no = {ni[NW-2:0], 1'b0};
    end
  endfunction

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic               vin;
    logic [DW-1:0]      dvs_in;
    logic [2:0][DW-1:0] rem_in;
    logic [2:0][NW-1:0] num_in;
    v3a_pkg::v3a_side_t side_in;
    logic [2:0][DW-1:0] rem_v;
    logic [2:0][NW-1:0] num_v;

    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign dvs_in  = in_divisor;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign side_in = in_side;
    end else begin : g_next
      assign vin     = vld_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_v = rem_in;
      num_v = num_in;
      for (int ln = 0; ln < 3; ln++) begin
        for (int s = 0; s < v3a_pkg::DIV_STEPS; s++) begin
          dv_step(rem_v[ln], num_v[ln], dvs_in, rem_v[ln], num_v[ln]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vin;
    end

    always_ff @(posedge clk) begin
      dvs_r[k]  <= dvs_in;
      rem_r[k]  <= rem_v;
      num_r[k]  <= num_v;
      side_r[k] <= side_in;
    end
  end

  assign out_valid   = vld_r[NS-1];
  assign out_divisor = dvs_r[NS-1];
  assign out_quot    = num_r[NS-1];
  assign out_side    = side_r[NS-1];

endmodule

// ===== test/tb_vector3_arith_unit.sv =====
// Self-checking testbench for vector3_arith_unit (Q16.16 3D vector unit).
// Depends on v3a_pkg; predicts each result with an exact wide-integer model.
module tb_vector3_arith_unit;

  localparam longint LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  v3a_pkg::v3a_in_t in_data = '0;
  logic busy;
  logic out_strobe;
  v3a_pkg::v3a_out_t out_data;

  v3a_pkg::v3a_out_t expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  longint cycle_count = 0;

  vector3_arith_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_strobe(out_strobe), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Clamp an exact value to 32 bits, flagging saturation.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round to nearest, ties away from zero, dropping FRAC_BITS.
  function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (128'sd1 <<< (v3a_pkg::FRAC_BITS - 1))) >>> v3a_pkg::FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [127:0] int_sqrt(input logic [127:0] n);
    logic [127:0] r, b;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= n) r = b;
    end
    return r;
  endfunction

  function automatic v3a_pkg::v3a_out_t predict_vector(input v3a_pkg::v3a_in_t x);
    v3a_pkg::v3a_out_t o;
    logic ovf;
    logic signed [127:0] a[3], b[3], s, r[3], sc, mg, num;
    logic [127:0] m;
    o = '0;
    ovf = 1'b0;
    a[0] = 128'(x.a_x); a[1] = 128'(x.a_y); a[2] = 128'(x.a_z);
    b[0] = 128'(x.b_x); b[1] = 128'(x.b_y); b[2] = 128'(x.b_z);
    s = 128'(x.scale_factor);
    case (x.operation)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          case (x.operation)
            v3a_pkg::OP_ADD:   r[i] = a[i] + b[i];
            v3a_pkg::OP_SUB:   r[i] = a[i] - b[i];
            v3a_pkg::OP_SCALE: r[i] = round_q(s * a[i]);
            default: r[i] = round_q(a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3]);
          endcase
        end
        o.r_x = clamp32(r[0], ovf);
        o.r_y = clamp32(r[1], ovf);
        o.r_z = clamp32(r[2], ovf);
      end
      v3a_pkg::OP_DOT: begin
        sc = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
        o.scalar_out = clamp32(sc, ovf);
      end
      v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: begin
        m = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (x.operation == v3a_pkg::OP_MAG) begin
          o.scalar_out = clamp32($signed(m), ovf);
        end else if (m == 0) begin
          o.zero_length = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num = ((a[i] < 0) ? -a[i] : a[i]) <<< v3a_pkg::FRAC_BITS;
            mg = (num + $signed(m / 2)) / $signed(m);
            r[i] = (a[i] < 0) ? -mg : mg;
          end
          o.r_x = clamp32(r[0], ovf);
          o.r_y = clamp32(r[1], ovf);
          o.r_z = clamp32(r[2], ovf);
        end
      end
      default: ;
    endcase
    o.overflow = ovf;
    return o;
  endfunction

  // Called at a falling edge; drops start only when a gap is taken.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drive one beat from a falling edge; start stays high if the next beat
  // follows immediately.
  task automatic send_item(input v3a_pkg::v3a_in_t x, input bit gaps);
    start <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_vector(x));
    items_sent++;
    @(negedge clk);
    if (gaps) idle_gap();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        v3a_pkg::v3a_out_t e;
        e = expected_q.pop_front();
        if (e !== out_data) begin
          $display("%0t mismatch exp x=%h y=%h z=%h s=%h ov=%b zl=%b", $time,
                   e.r_x, e.r_y, e.r_z, e.scalar_out, e.overflow, e.zero_length);
          $display("%0t          got x=%h y=%h z=%h s=%h ov=%b zl=%b", $time,
                   out_data.r_x, out_data.r_y, out_data.r_z, out_data.scalar_out,
                   out_data.overflow, out_data.zero_length);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(0, 1) ? 32'd0 : 32'h00010000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    v3a_pkg::v3a_in_t x;
    logic [31:0] ext[4];
    ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = 32'h0; ext[3] = 32'hffffffff;
    for (int op = 0; op < 8; op++) begin
      for (int k = 0; k < 2; k++) begin
        x.operation = op[2:0];
        x.a_x = ext[k]; x.a_y = ext[k+1]; x.a_z = ext[3-k];
        x.b_x = ext[1-k]; x.b_y = ext[3]; x.b_z = ext[k];
        x.scale_factor = ext[k];
        send_item(x, 1'b0);
      end
    end
    x = '0;
    x.operation = v3a_pkg::OP_NORM;   // zero vector
    send_item(x, 1'b0);
    x.operation = v3a_pkg::OP_NORM;
    x.a_x = 32'h00030000; x.a_y = 32'h00040000;
    send_item(x, 1'b0);
    x.operation = v3a_pkg::OP_MAG;
    send_item(x, 1'b0);
    x.operation = v3a_pkg::OP_NORM;  // tiny vector, large quotient
    x.a_x = 32'h1; x.a_y = 32'h0;
    send_item(x, 1'b0);
    x.operation = v3a_pkg::OP_SCALE;
    x.scale_factor = 32'h00008000; x.a_x = 32'h1; x.a_y = 32'hffffffff;
    x.a_z = 32'h3;
    send_item(x, 1'b0);
  endtask

  task automatic test_random(input int count);
    v3a_pkg::v3a_in_t x;
    for (int i = 0; i < count; i++) begin
      x.operation = 3'($urandom_range(0, 7));
      x.a_x = rand_word(); x.a_y = rand_word(); x.a_z = rand_word();
      x.b_x = rand_word(); x.b_y = rand_word(); x.b_z = rand_word();
      x.scale_factor = rand_word();
      if (x.operation == v3a_pkg::OP_NORM && $urandom_range(0, 9) == 0) begin
        x.a_x = '0; x.a_y = '0; x.a_z = '0;
      end
      send_item(x, (i % 100) >= 30);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(500);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats over all operations, extremes and zero-vector normalize;",
             items_sent);
    $display("checked %0d results, %0d errors.", results_seen, errors);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== vector3_arith_unit.f =====
sv/v3a_pkg.sv
sv/v3a_isqrt.sv
sv/v3a_divider.sv
sv/vector3_arith_unit.sv
test/tb_vector3_arith_unit.sv
